// File: design/djt_pkg.sv
package djt_pkg;

  // Angle and trig widths
  localparam int ANGLE_WIDTH = 16;
  localparam int TRIG_WIDTH  = 16;

  // Fixed register and position widths
  localparam int TWIST_W    = 16;
  localparam int LEN_W      = 32;
  localparam int TWIST_FRAC = 15;

  // Polynomial datapath: Q1.30 magnitudes
  localparam int Z_FRAC      = 30;
  localparam int Z_W         = Z_FRAC + 1;
  localparam int PHASE_SHIFT = Z_FRAC - (ANGLE_WIDTH - 2);

  localparam logic [Z_W-1:0] COEF_A1 = Z_W'(1686629713);
  localparam logic [Z_W-1:0] COEF_A3 = Z_W'(693598669);
  localparam logic [Z_W-1:0] COEF_A5 = Z_W'(85569306);
  localparam logic [Z_W-1:0] COEF_A7 = Z_W'(5026995);
  localparam logic [Z_W-1:0] COEF_A9 = Z_W'(172272);

  localparam int TRIG_TOP = 2 ** (TRIG_WIDTH - 1) - 1;
  localparam int SC_STAGES = 8;

  // Link product widths
  localparam int RP_W = TRIG_WIDTH + TWIST_W;
  localparam int PP_W = TRIG_WIDTH + LEN_W;

  // Stream widths, padded to bytes
  localparam int IN_DATA_W  = ((ANGLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_BITS   = 6 * TRIG_WIDTH + 2 * TWIST_W + 3 * LEN_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = LEN_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COS_TWIST   = 4'd0,
    REG_SIN_TWIST   = 4'd1,
    REG_LINK_LENGTH = 4'd2,
    REG_LINK_OFFSET = 4'd3
  } cfg_reg_t;

  typedef logic signed [TRIG_WIDTH-1:0] trig_t;
  typedef logic signed [TWIST_W-1:0]    twist_t;
  typedef logic signed [LEN_W-1:0]      len_t;
  typedef logic [Z_W-1:0]               zq_t;

  localparam trig_t TRIG_MIN = trig_t'(-TRIG_TOP - 1);

  typedef struct packed {
    trig_t sin_v;
    trig_t cos_v;
  } trig_pair_t;

  typedef struct packed {
    twist_t cos_twist;
    twist_t sin_twist;
    len_t   link_length;
    len_t   link_offset;
  } cfg_t;

  typedef struct packed {
    len_t   pos_z;
    twist_t rot_22;
    twist_t rot_21;
    len_t   pos_y;
    trig_t  rot_12;
    trig_t  rot_11;
    trig_t  rot_10;
    len_t   pos_x;
    trig_t  rot_02;
    trig_t  rot_01;
    trig_t  rot_00;
  } result_t;

endpackage

// File: design/djt_sincos.sv
module djt_sincos (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [djt_pkg::ANGLE_WIDTH-1:0]  in_angle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output djt_pkg::trig_pair_t              out_trig
);
  import djt_pkg::*;

  typedef logic [1:0] quad_t;

  // lane 0 = sine, lane 1 = cosine
  logic [SC_STAGES-1:0] v_r;
  logic [SC_STAGES-1:0] en;

  zq_t   z0_r [2];
  quad_t qd0_r [2];
  zq_t   zz1_r [2], z1_r [2];
  quad_t qd1_r [2];
  zq_t   r2_r [2], zz2_r [2], z2_r [2];
  quad_t qd2_r [2];
  zq_t   r3_r [2], zz3_r [2], z3_r [2];
  quad_t qd3_r [2];
  zq_t   r4_r [2], zz4_r [2], z4_r [2];
  quad_t qd4_r [2];
  zq_t   r5_r [2], z5_r [2];
  quad_t qd5_r [2];
  zq_t   m6_r [2];
  quad_t qd6_r [2];
  trig_t t7_r [2];

  logic [ANGLE_WIDTH-1:0] phase [2];

  function automatic zq_t fold_z(input logic [ANGLE_WIDTH-1:0] p);
    logic [ANGLE_WIDTH-3:0] x;
    logic [ANGLE_WIDTH-2:0] xf;
    begin
      x = p[ANGLE_WIDTH-3:0];
      if (p[ANGLE_WIDTH-2]) begin
        xf = (ANGLE_WIDTH-1)'(1 << (ANGLE_WIDTH - 2)) - {1'b0, x};
      end else begin
        xf = {1'b0, x};
      end
      fold_z = Z_W'(xf) << PHASE_SHIFT;
    end
  endfunction

  // (a * b) >> 30 on Q1.30 magnitudes
  function automatic zq_t mulq(input zq_t a, input zq_t b);
    logic [2*Z_W-1:0] p;
    begin
      p = (2*Z_W)'(a) * (2*Z_W)'(b);
      mulq = p[Z_W+Z_FRAC-1:Z_FRAC];
    end
  endfunction

  function automatic trig_t round_sign(input zq_t m, input quad_t q);
    logic [Z_W:0] rr;
    logic [Z_W:0] mag;
    trig_t        t;
    begin
      rr  = {1'b0, m} + ((Z_W+1)'(1) << (Z_FRAC - TRIG_WIDTH));
      mag = rr >> (Z_FRAC + 1 - TRIG_WIDTH);
      if (mag > (Z_W+1)'(TRIG_TOP)) begin
        t = trig_t'(TRIG_TOP);
      end else begin
        t = trig_t'(mag[TRIG_WIDTH-1:0]);
      end
      round_sign = q[1] ? -t : t;
    end
  endfunction

  assign phase[0] = in_angle;
  assign phase[1] = in_angle + ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 2));

  // a stage loads when empty or when the next one moves
  always_comb begin
    en[SC_STAGES-1] = !v_r[SC_STAGES-1] || out_ready;
    for (int k = SC_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[SC_STAGES-1];
  assign out_trig.sin_v = t7_r[0];
  assign out_trig.cos_v = t7_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < SC_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (en[0]) begin
        z0_r[l]  <= fold_z(phase[l]);
        qd0_r[l] <= phase[l][ANGLE_WIDTH-1:ANGLE_WIDTH-2];
      end
      if (en[1]) begin
        zz1_r[l] <= mulq(z0_r[l], z0_r[l]);
        z1_r[l]  <= z0_r[l];
        qd1_r[l] <= qd0_r[l];
      end
      if (en[2]) begin
        r2_r[l]  <= COEF_A7 - mulq(zz1_r[l], COEF_A9);
        zz2_r[l] <= zz1_r[l];
        z2_r[l]  <= z1_r[l];
        qd2_r[l] <= qd1_r[l];
      end
      if (en[3]) begin
        r3_r[l]  <= COEF_A5 - mulq(zz2_r[l], r2_r[l]);
        zz3_r[l] <= zz2_r[l];
        z3_r[l]  <= z2_r[l];
        qd3_r[l] <= qd2_r[l];
      end
      if (en[4]) begin
        r4_r[l]  <= COEF_A3 - mulq(zz3_r[l], r3_r[l]);
        zz4_r[l] <= zz3_r[l];
        z4_r[l]  <= z3_r[l];
        qd4_r[l] <= qd3_r[l];
      end
      if (en[5]) begin
        r5_r[l]  <= COEF_A1 - mulq(zz4_r[l], r4_r[l]);
        z5_r[l]  <= z4_r[l];
        qd5_r[l] <= qd4_r[l];
      end
      if (en[6]) begin
        m6_r[l]  <= mulq(z5_r[l], r5_r[l]);
        qd6_r[l] <= qd5_r[l];
      end
      if (en[7]) begin
        t7_r[l] <= round_sign(m6_r[l], qd6_r[l]);
      end
    end
  end

`ifndef SYNTHESIS
  a_trig_never_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_trig.sin_v != TRIG_MIN) && (out_trig.cos_v != TRIG_MIN))
    else $error("sine or cosine left the saturated range");

  a_first_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !en[1] |=> v_r[0])
    else $error("stalled item dropped from first stage");
`endif

endmodule

// File: design/djt_link.sv
module djt_link (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  djt_pkg::trig_pair_t  in_trig,
  input  djt_pkg::cfg_t        cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output djt_pkg::result_t     out_res
);
  import djt_pkg::*;

  typedef logic signed [RP_W-1:0] rprod_t;
  typedef logic signed [PP_W-1:0] pprod_t;

  logic       v1_r, v2_r;
  logic       en1, en2;
  rprod_t     p_cca_r, p_sca_r, p_ssa_r, p_csa_r;
  pprod_t     p_lc_r, p_ls_r;
  trig_pair_t trig1_r;
  twist_t     ca1_r, sa1_r;
  len_t       off1_r;
  result_t    res_r, res_nxt;

  // trig * Q1.15 register, optional negate, round half up, saturate
  function automatic trig_t round_trig(input rprod_t p, input logic neg);
    logic signed [RP_W:0]            q;
    logic signed [RP_W-TWIST_FRAC:0] sh;
    begin
      q = p;
      if (neg) begin
        q = -q;
      end
      q  = q + ((RP_W+1)'(1) << (TWIST_FRAC - 1));
      sh = q[RP_W:TWIST_FRAC];
      if (sh > TRIG_TOP) begin
        round_trig = trig_t'(TRIG_TOP);
      end else if (sh < -TRIG_TOP - 1) begin
        round_trig = TRIG_MIN;
      end else begin
        round_trig = trig_t'(sh);
      end
    end
  endfunction

  // length * trig, shift by trig fraction, round half up, saturate
  function automatic len_t round_pos(input pprod_t p);
    logic signed [PP_W:0]              q;
    logic signed [PP_W-TRIG_WIDTH+1:0] sh;
    begin
      q  = p;
      q  = q + ((PP_W+1)'(1) << (TRIG_WIDTH - 2));
      sh = q[PP_W:TRIG_WIDTH-1];
      if (sh > (PP_W-TRIG_WIDTH+2)'(32'sh7fffffff)) begin
        round_pos = 32'sh7fffffff;
      end else if (sh < -(PP_W-TRIG_WIDTH+2)'(33'sh080000000)) begin
        round_pos = 32'sh80000000;
      end else begin
        round_pos = len_t'(sh);
      end
    end
  endfunction

  assign en2       = !v2_r || out_ready;
  assign en1       = !v1_r || en2;
  assign in_ready  = en1;
  assign out_valid = v2_r;
  assign out_res   = res_r;

  always_comb begin
    res_nxt.rot_00 = trig1_r.cos_v;
    res_nxt.rot_01 = round_trig(p_sca_r, 1'b1);
    res_nxt.rot_02 = round_trig(p_ssa_r, 1'b0);
    res_nxt.pos_x  = round_pos(p_lc_r);
    res_nxt.rot_10 = trig1_r.sin_v;
    res_nxt.rot_11 = round_trig(p_cca_r, 1'b0);
    res_nxt.rot_12 = round_trig(p_csa_r, 1'b1);
    res_nxt.pos_y  = round_pos(p_ls_r);
    res_nxt.rot_21 = sa1_r;
    res_nxt.rot_22 = ca1_r;
    res_nxt.pos_z  = off1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p_cca_r <= in_trig.cos_v * cfg.cos_twist;
      p_sca_r <= in_trig.sin_v * cfg.cos_twist;
      p_ssa_r <= in_trig.sin_v * cfg.sin_twist;
      p_csa_r <= in_trig.cos_v * cfg.sin_twist;
      p_lc_r  <= cfg.link_length * in_trig.cos_v;
      p_ls_r  <= cfg.link_length * in_trig.sin_v;
      trig1_r <= in_trig;
      ca1_r   <= cfg.cos_twist;
      sa1_r   <= cfg.sin_twist;
      off1_r  <= cfg.link_offset;
    end
    if (en2) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_zero_twist_sine: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.rot_21 == '0) |-> (out_res.rot_02 == '0) && (out_res.rot_12 == '0))
    else $error("zero twist sine gave nonzero rotation terms");

  a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v2_r) && ($past(cfg.link_length, 2) == '0) |-> (out_res.pos_x == '0) &&
      (out_res.pos_y == '0))
    else $error("zero link length gave nonzero position");
`endif

endmodule

// File: design/dh_joint_transform_top.sv
// Denavit-Hartenberg link transform, one joint angle per request.
//
// Input stream: in_tdata carries the joint angle as a binary angle
// (half turn = 32768). Output stream: out_tdata carries the eleven
// non-constant entries of the 4x4 link matrix; rotation entries are Q1.15,
// positions Q16.16.
// Config port: cfg_wr_en with cfg_addr/cfg_wdata writes cos_twist (0),
// sin_twist (1), link_length (2) or link_offset (3); other addresses are
// ignored. Write only while no request is in flight.
//
// Pipeline: 8 stages of sine/cosine polynomial, one product stage, one
// round/saturate stage that is the output register. Throughput: one request
// per cycle while out_tready is high; no stage has more than one multiply in
// series, the widest being 31x31 in the polynomial and 32x16 in the link.
// Reset (rst_n low, synchronous) empties the pipeline and loads
// cos_twist = 32767, the other registers 0.
// When out_tready is low, stages fill up behind the output register and
// in_tready drops only once the whole pipeline is full; nothing is lost.
module dh_joint_transform_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] joint_angle
  input  logic [djt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // rot_00, rot_01, rot_02, pos_x, rot_10, rot_11, rot_12, pos_y,
  // rot_21, rot_22, pos_z (low to high)
  output logic [djt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [djt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [djt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import djt_pkg::*;

  cfg_t       cfg_r;
  trig_pair_t trig;
  logic       trig_valid, trig_ready;
  result_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_twist   <= {1'b0, {(TWIST_W-1){1'b1}}};
      cfg_r.sin_twist   <= '0;
      cfg_r.link_length <= '0;
      cfg_r.link_offset <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_COS_TWIST:   cfg_r.cos_twist   <= cfg_wdata[TWIST_W-1:0];
        REG_SIN_TWIST:   cfg_r.sin_twist   <= cfg_wdata[TWIST_W-1:0];
        REG_LINK_LENGTH: cfg_r.link_length <= cfg_wdata[LEN_W-1:0];
        REG_LINK_OFFSET: cfg_r.link_offset <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  djt_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_angle  (in_tdata[ANGLE_WIDTH-1:0]),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_trig  (trig)
  );

  djt_link u_link (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (trig_valid),
    .in_ready  (trig_ready),
    .in_trig   (trig),
    .cfg       (cfg_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = OUT_DATA_W'({res.pos_z, res.rot_22, res.rot_21, res.pos_y,
                                  res.rot_12, res.rot_11, res.rot_10, res.pos_x,
                                  res.rot_02, res.rot_01, res.rot_00});

`ifndef SYNTHESIS
  a_cfg_len_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && (cfg_addr == REG_LINK_LENGTH) |=> cfg_r.link_length == $past(cfg_wdata))
    else $error("link length write lost");
`endif

endmodule
